// ===== design/tbls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_pkg
// Shared sizes, control word layout and microprogram for the two-ship
// loading search.
// ----------------------------------------------------------------------------
package tbls_pkg;

    // Sizing
    localparam int MAX_ITEMS   = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int LVL_W       = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W       = WEIGHT_BITS + IDX_W + 1;

    // Fixed field widths
    localparam int IN_WEIGHT_W = 16;
    localparam int CAP_W       = 20;
    localparam int BEST_W      = 20;
    localparam int MASK_W      = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 40;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register indexes
    localparam logic REG_FIRST_CAP  = 1'b0;
    localparam logic REG_SECOND_CAP = 1'b1;

    // Microprogram
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [UPC_W-1:0] A_INIT    = 4'd1;
    localparam logic [UPC_W-1:0] A_UP      = 4'd2;
    localparam logic [UPC_W-1:0] A_UP_WAIT = 4'd3;
    localparam logic [UPC_W-1:0] A_UP_CHK  = 4'd4;
    localparam logic [UPC_W-1:0] A_UP_DROP = 4'd5;
    localparam logic [UPC_W-1:0] A_UP_EX   = 4'd6;
    localparam logic [UPC_W-1:0] A_DOWN    = 4'd7;
    localparam logic [UPC_W-1:0] A_TRY_IN  = 4'd8;
    localparam logic [UPC_W-1:0] A_TRY_EX  = 4'd9;
    localparam logic [UPC_W-1:0] A_EX_BACK = 4'd10;
    localparam logic [UPC_W-1:0] A_LEAF    = 4'd11;
    localparam logic [UPC_W-1:0] A_FINISH  = 4'd12;
    localparam logic [UPC_W-1:0] A_RETURN  = 4'd13;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_INIT    = 4'd1,
        OP_INCLUDE = 4'd2,
        OP_EXCLUDE = 4'd3,
        OP_DEC     = 4'd4,
        OP_UNDONE  = 4'd5,
        OP_DROP    = 4'd6,
        OP_BEST    = 4'd7,
        OP_PUBLISH = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_START    = 3'd1,
        C_LEAF     = 3'd2,
        C_FIT      = 3'd3,
        C_BOUND    = 3'd4,
        C_LVL0     = 3'd5,
        C_DONE_BIT = 3'd6,
        C_OUT_FREE = 3'd7
    } t_cond;

    typedef enum logic [1:0] {
        G_ALWAYS    = 2'd0,
        G_TAKEN     = 2'd1,
        G_NOT_TAKEN = 2'd2
    } t_gate;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic             neg;
        t_gate            gate;
        logic [UPC_W-1:0] target;
    } t_ctrl;

    // Datapath status
    typedef struct packed {
        logic leaf;
        logic fit;
        logic bound;
        logic lvl0;
        logic done_bit;
    } t_dp_flags;

    // Everything the sequencer branches on
    typedef struct packed {
        logic      start;
        logic      out_free;
        t_dp_flags dp;
    } t_flags;

    typedef struct packed {
        logic              feasible;
        logic [BEST_W-1:0] best_weight;
        logic [MASK_W-1:0] mask;
    } t_result;

    // Control store
    function automatic t_ctrl rom(input logic [UPC_W-1:0] a);
        t_ctrl c;
        c = '{op: OP_NONE, cond: C_ALWAYS, neg: 1'b0, gate: G_ALWAYS, target: A_IDLE};
        case (a)
            A_IDLE:    c = '{OP_NONE,    C_START,    1'b1, G_ALWAYS,    A_IDLE};
            A_INIT:    c = '{OP_INIT,    C_ALWAYS,   1'b0, G_ALWAYS,    A_DOWN};
            A_UP:      c = '{OP_DEC,     C_LVL0,     1'b0, G_NOT_TAKEN, A_FINISH};
            A_UP_WAIT: c = '{OP_NONE,    C_ALWAYS,   1'b0, G_ALWAYS,    A_UP_CHK};
            A_UP_CHK:  c = '{OP_UNDONE,  C_DONE_BIT, 1'b0, G_TAKEN,     A_UP};
            A_UP_DROP: c = '{OP_DROP,    C_ALWAYS,   1'b0, G_ALWAYS,    A_UP_EX};
            A_UP_EX:   c = '{OP_EXCLUDE, C_BOUND,    1'b1, G_NOT_TAKEN, A_UP};
            A_DOWN:    c = '{OP_NONE,    C_LEAF,     1'b0, G_ALWAYS,    A_LEAF};
            A_TRY_IN:  c = '{OP_INCLUDE, C_FIT,      1'b0, G_TAKEN,     A_DOWN};
            A_TRY_EX:  c = '{OP_EXCLUDE, C_BOUND,    1'b0, G_TAKEN,     A_DOWN};
            A_EX_BACK: c = '{OP_NONE,    C_ALWAYS,   1'b0, G_ALWAYS,    A_UP};
            A_LEAF:    c = '{OP_BEST,    C_ALWAYS,   1'b0, G_ALWAYS,    A_UP};
            A_FINISH:  c = '{OP_PUBLISH, C_OUT_FREE, 1'b1, G_NOT_TAKEN, A_FINISH};
            A_RETURN:  c = '{OP_NONE,    C_ALWAYS,   1'b0, G_ALWAYS,    A_IDLE};
            default:   c = '{OP_NONE,    C_ALWAYS,   1'b0, G_ALWAYS,    A_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ===== design/tbls_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tbls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tbls_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_seq
// Microprogram sequencer: step counter, control store and branch logic.
// ----------------------------------------------------------------------------
module tbls_seq import tbls_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_op    o_op,
    output logic   o_idle
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_ctrl            w_ctrl;
    logic             w_hit;
    logic             w_taken;
    logic             w_fire;

    // Condition select
    always_comb begin
        w_ctrl = rom(r_upc);
        unique case (w_ctrl.cond)
            C_ALWAYS:   w_hit = 1'b1;
            C_START:    w_hit = i_flags.start;
            C_LEAF:     w_hit = i_flags.dp.leaf;
            C_FIT:      w_hit = i_flags.dp.fit;
            C_BOUND:    w_hit = i_flags.dp.bound;
            C_LVL0:     w_hit = i_flags.dp.lvl0;
            C_DONE_BIT: w_hit = i_flags.dp.done_bit;
            C_OUT_FREE: w_hit = i_flags.out_free;
            default:    w_hit = 1'b0;
        endcase
        w_taken = w_hit ^ w_ctrl.neg;
        n_upc   = w_taken ? w_ctrl.target : r_upc + 1'b1;
    end

    // Gate the datapath operation on the branch outcome
    always_comb begin
        unique case (w_ctrl.gate)
            G_ALWAYS:    w_fire = 1'b1;
            G_TAKEN:     w_fire = w_taken;
            G_NOT_TAKEN: w_fire = ~w_taken;
            default:     w_fire = 1'b0;
        endcase
        o_op = w_fire ? w_ctrl.op : OP_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= A_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_idle = (r_upc == A_IDLE);

endmodule

// ===== design/tbls_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_dp
// Search datapath: weight store, running sums, path and branch masks, best.
// ----------------------------------------------------------------------------
module tbls_dp import tbls_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic [CAP_W-1:0]       i_cap1,
    input  logic [CAP_W-1:0]       i_cap2,
    input  t_op                    i_op,
    output t_dp_flags              o_flags,
    output t_result                o_res
);

    logic [LVL_W-1:0]       r_count;
    logic [SUM_W-1:0]       r_total;
    logic [SUM_W-1:0]       r_best;
    logic [MAX_ITEMS-1:0]   r_best_mask;
    logic [MAX_ITEMS-1:0]   r_path;
    logic [MAX_ITEMS-1:0]   r_done;
    logic [LVL_W-1:0]       r_level;
    logic [SUM_W-1:0]       r_running;
    logic [SUM_W-1:0]       r_remaining;

    logic [SUM_W-1:0]       n_best;
    logic [MAX_ITEMS-1:0]   n_best_mask;
    logic [MAX_ITEMS-1:0]   n_path;
    logic [MAX_ITEMS-1:0]   n_done;
    logic [LVL_W-1:0]       n_level;
    logic [SUM_W-1:0]       n_running;
    logic [SUM_W-1:0]       n_remaining;

    logic [WEIGHT_BITS-1:0] w_rd;
    logic [SUM_W-1:0]       w_w;
    logic [SUM_W-1:0]       w_inc_sum;
    logic [SUM_W-1:0]       w_exc_sum;
    logic [SUM_W-1:0]       w_leftover;
    logic [MAX_ITEMS-1:0]   w_bit;
    logic                   w_store;

    // Weight store, read at the current level every cycle
    assign w_store = i_load && (r_count < LVL_W'(MAX_ITEMS));

    tbls_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_weight),
        .i_raddr (r_level[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    // Branch tests
    assign w_w       = SUM_W'(w_rd);
    assign w_bit     = MAX_ITEMS'(1) << r_level[IDX_W-1:0];
    assign w_inc_sum = r_running + w_w;
    assign w_exc_sum = r_running + r_remaining - w_w;

    assign o_flags.leaf     = (r_level >= r_count);
    assign o_flags.fit      = (w_inc_sum <= SUM_W'(i_cap1));
    assign o_flags.bound    = (w_exc_sum > r_best);
    assign o_flags.lvl0     = (r_level == '0);
    assign o_flags.done_bit = r_done[r_level[IDX_W-1:0]];

    // Result, taken by the output register on publish
    assign w_leftover        = r_total - r_best;
    assign o_res.feasible    = (w_leftover <= SUM_W'(i_cap2));
    assign o_res.best_weight = BEST_W'(r_best);
    assign o_res.mask        = MASK_W'(r_best_mask);

    // Search step
    always_comb begin
        n_best      = r_best;
        n_best_mask = r_best_mask;
        n_path      = r_path;
        n_done      = r_done;
        n_level     = r_level;
        n_running   = r_running;
        n_remaining = r_remaining;
        unique case (i_op)
            OP_NONE, OP_PUBLISH: begin
            end
            OP_INIT: begin
                n_best      = '0;
                n_best_mask = '0;
                n_path      = '0;
                n_done      = '0;
                n_level     = '0;
                n_running   = '0;
                n_remaining = r_total;
            end
            OP_INCLUDE: begin
                n_path      = r_path | w_bit;
                n_running   = w_inc_sum;
                n_remaining = r_remaining - w_w;
                n_level     = r_level + 1'b1;
            end
            OP_EXCLUDE: begin
                n_done      = r_done | w_bit;
                n_remaining = r_remaining - w_w;
                n_level     = r_level + 1'b1;
            end
            OP_DEC: begin
                n_level = r_level - 1'b1;
            end
            OP_UNDONE: begin
                n_done      = r_done & ~w_bit;
                n_remaining = r_remaining + w_w;
            end
            OP_DROP: begin
                n_path      = r_path & ~w_bit;
                n_running   = r_running - w_w;
                n_remaining = r_remaining + w_w;
            end
            OP_BEST: begin
                // strictly heavier only: the first of equal sums stays
                if (r_running > r_best) begin
                    n_best      = r_running;
                    n_best_mask = r_path;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_best_mask <= '0;
            r_path      <= '0;
            r_done      <= '0;
            r_level     <= '0;
            r_running   <= '0;
            r_remaining <= '0;
        end else begin
            r_best      <= n_best;
            r_best_mask <= n_best_mask;
            r_path      <= n_path;
            r_done      <= n_done;
            r_level     <= n_level;
            r_running   <= n_running;
            r_remaining <= n_remaining;
        end
    end

    // Job bookkeeping; containers beyond capacity of the store are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_op == OP_PUBLISH) begin
            r_count <= '0;
            r_total <= '0;
        end else if (w_store) begin
            r_count <= r_count + 1'b1;
            r_total <= r_total + SUM_W'(i_weight);
        end
    end

endmodule

// ===== design/two_bin_loading_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_bin_loading_search
// Two-ship container loading: weights stream in, a microcoded branch-and-bound
// search finds the heaviest load for ship one and checks the rest on ship two.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_axis   | in        | tdata[15:0] weight, tlast = last container of job
//  m_axis   | out       | tdata[0] feasible, [20:1] best_weight,
//           |           | [36:21] first_ship_mask, [39:37] zero
//  APB      | in/out    | 0x0 first_capacity, 0x4 second_capacity (20 bits)
//
// A container with tlast low is accepted as soon as it is valid, back to back.
// The transaction with tlast high starts the search; s_axis_tready stays low
// from then until the sequencer steps from its return step back to idle, after the result enters the output register.
// The search runs at one microinstruction per cycle, so its length depends on
// the weights and capacities.
// The result waits in the output register while m_axis_tready is low; the
// sequencer holds at its final step until that register is free.
// Reset is synchronous and active low; capacities reset to zero.
// ----------------------------------------------------------------------------
module two_bin_loading_search import tbls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Container stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] weight
    input  logic                  s_axis_tlast,
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // feasible, best_weight, first_ship_mask
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0]      r_cap1;
    logic [CAP_W-1:0]      r_cap2;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    t_op       w_op;
    logic      w_idle;
    logic      w_in_acc;
    t_flags    w_flags;
    t_dp_flags w_dp_flags;
    t_result   w_res;
    logic      w_reg_sel;

    // Register port
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap1 <= '0;
            r_cap2 <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_sel)
                REG_FIRST_CAP:  r_cap1 <= pwdata[CAP_W-1:0];
                REG_SECOND_CAP: r_cap2 <= pwdata[CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_FIRST_CAP:  prdata = APB_DATA_W'(r_cap1);
            REG_SECOND_CAP: prdata = APB_DATA_W'(r_cap2);
            default:        prdata = '0;
        endcase
    end

    // Input side
    assign s_axis_tready = w_idle;
    assign w_in_acc      = s_axis_tvalid && w_idle;

    assign w_flags.start    = w_in_acc && s_axis_tlast;
    assign w_flags.out_free = !r_m_valid || m_axis_tready;
    assign w_flags.dp       = w_dp_flags;

    tbls_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op),
        .o_idle  (w_idle)
    );

    tbls_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_in_acc),
        .i_weight (s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_cap1   (r_cap1),
        .i_cap2   (r_cap2),
        .i_op     (w_op),
        .o_flags  (w_dp_flags),
        .o_res    (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_op == OP_PUBLISH) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == OP_PUBLISH) begin
            r_m_data <= OUT_DATA_W'({w_res.mask, w_res.best_weight, w_res.feasible});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== design/tbls_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_chk
// Port-level checks for the loading search, bound to the top level.
// ----------------------------------------------------------------------------
module tbls_chk import tbls_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tlast,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  pready
);

    // A held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The closing container of a job starts the search and blocks input
    a_search_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during search");

    // An empty first-ship load and a zero best weight go together
    a_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[MASK_W+BEST_W:BEST_W+1] == '0) ==
             (m_axis_tdata[BEST_W:1] == '0)))
        else $error("mask and best weight disagree");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind two_bin_loading_search tbls_chk u_tbls_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
